### src/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; imported by cbm_translate, the top, cbm_checker and tb.
package cbm_pkg;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int OFFSET_W = 21;
    localparam int NUM_BANK_REGS = 8;
    localparam int CFG_INDEX_W = 2;

    // Result target codes
    typedef enum logic [2:0] {
        TGT_PRG  = 3'd0,
        TGT_CHR  = 3'd1,
        TGT_VRAM = 3'd2,
        TGT_CART = 3'd3,
        TGT_NONE = 3'd4
    } target_t;

    // Access modes
    typedef enum logic [1:0] {
        MODE_REG_WRITE = 2'd0,
        MODE_PRG_READ  = 2'd1,
        MODE_CHR_READ  = 2'd2,
        MODE_NT_ACCESS = 2'd3
    } mode_t;

    // Mapper register decode on {address[14], address[13], address[0]}
    localparam logic [2:0] REG_BANK_SELECT = 3'b000;
    localparam logic [2:0] REG_BANK_DATA   = 3'b001;
    localparam logic [2:0] REG_MIRRORING   = 3'b010;
    localparam logic [2:0] REG_WRAM_CTRL   = 3'b011;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANK_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_SCREEN    = 2'd2;

    localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 9'd64;
    localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = 9'd256;

    // Mapper state seen by the translation logic
    typedef struct packed {
        logic [NUM_BANK_REGS-1:0][DATA_W-1:0] banks;
        logic                                 chr_swap;
        logic                                 prg_swap;
        logic                                 horiz_mirroring;
        logic                                 four_screen;
        logic [COUNT_W-1:0]                   prg_count;
        logic [COUNT_W-1:0]                   chr_count;
    } map_state_t;

    // One translated access
    typedef struct packed {
        target_t               target;
        logic [OFFSET_W-1:0]   offset;
        logic                  out_of_range;
    } xlate_t;

endpackage

### src/cbm_translate.sv
// Address translation for one access: PRG, CHR and nametable mapping.
// Depends on cbm_pkg; purely combinational, used by cartridge_bank_mapper_top.
module cbm_translate
    import cbm_pkg::*;
(
    input  mode_t               mode,
    input  logic [ADDR_W-1:0]   address,
    input  map_state_t          state,
    output xlate_t              result
);

    logic [13:0]        ppu;
    logic [COUNT_W-1:0] second_last;
    logic [COUNT_W-1:0] last;
    logic [COUNT_W-1:0] prg_bank;
    logic [2:0]         chr_win;
    logic [DATA_W-1:0]  chr_pair;
    logic [DATA_W-1:0]  chr_bank;
    logic [1:0]         nt;
    logic               nt_page;

    assign ppu         = address[13:0];
    assign second_last = state.prg_count - COUNT_W'(2);
    assign last        = state.prg_count - COUNT_W'(1);

    // PRG: select the 8 KB bank for the window
    always_comb
    begin
        case (address[14:13])
            2'd0:    prg_bank = state.prg_swap ? second_last : {1'b0, state.banks[6]};
            2'd1:    prg_bank = {1'b0, state.banks[7]};
            2'd2:    prg_bank = state.prg_swap ? {1'b0, state.banks[6]} : second_last;
            default: prg_bank = last;
        endcase
    end

    // CHR: swap mode flips the 2 KB pair half with the 1 KB half
    assign chr_win  = ppu[12:10] ^ {state.chr_swap, 2'b00};
    assign chr_pair = state.banks[{2'b00, chr_win[1]}];

    always_comb
    begin
        if (!chr_win[2])
        begin
            chr_bank = {chr_pair[DATA_W-1:1], chr_win[0]};
        end
        else
        begin
            chr_bank = state.banks[3'({1'b0, chr_win[1:0]}) + 3'd2];
        end
    end

    assign nt = ppu[11:10];

    always_comb
    begin
        if (state.four_screen || !state.horiz_mirroring)
        begin
            nt_page = nt[0];
        end
        else
        begin
            nt_page = nt[1];
        end
    end

    always_comb
    begin
        result.target       = TGT_NONE;
        result.offset       = '0;
        result.out_of_range = 1'b0;
        case (mode)
            MODE_PRG_READ:
            begin
                if (address[15])
                begin
                    result.target       = TGT_PRG;
                    result.offset       = {prg_bank[7:0], address[12:0]};
                    result.out_of_range = (prg_bank >= state.prg_count);
                end
            end
            MODE_CHR_READ:
            begin
                if (!ppu[13])
                begin
                    result.target       = TGT_CHR;
                    result.offset       = OFFSET_W'({chr_bank, ppu[9:0]});
                    result.out_of_range = ({1'b0, chr_bank} >= state.chr_count);
                end
            end
            MODE_NT_ACCESS:
            begin
                // Palette space and pattern space have no nametable target
                if (ppu[13] && !(ppu[12:8] == 5'h1F))
                begin
                    result.target = (state.four_screen && nt[1]) ? TGT_CART : TGT_VRAM;
                    result.offset = OFFSET_W'({nt_page, ppu[9:0]});
                end
            end
            default:
            begin
                result.target = TGT_NONE;
            end
        endcase
    end

endmodule

### src/cartridge_bank_mapper_top.sv
// Cartridge bank mapper top level: mapper registers, config registers, result register.
// Depends on cbm_pkg and cbm_translate.
//
// The mapper takes one bus access per clock while in_ready is high and returns one
// result per access, in the cycle after the access is accepted. All translation is
// done in a single pass of logic between the input handshake and the result register;
// the result register decouples the two sides, so a new access is taken whenever the
// result register is empty or its beat is being taken in the same cycle. A register
// write (mode 0) updates the mapper state at the accepting edge, so the very next
// access already sees it. Configuration writes (bank counts, four-screen) take effect
// at the edge that samples cfg_we and should be made while no access is in flight.
module cartridge_bank_mapper_top
    import cbm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             mode,
    input  logic [ADDR_W-1:0]      address,
    input  logic [DATA_W-1:0]      data_byte,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             target,
    output logic [OFFSET_W-1:0]    mapped_offset,
    output logic                   bank_out_of_range,
    output logic                   wram_enabled,
    output logic                   wram_writable
);

    logic [NUM_BANK_REGS-1:0][DATA_W-1:0] banks_reg;
    logic [NUM_BANK_REGS-1:0][DATA_W-1:0] banks_next;
    logic [2:0]          bank_select_reg, bank_select_next;
    logic                chr_swap_reg, chr_swap_next;
    logic                prg_swap_reg, prg_swap_next;
    logic                horiz_reg, horiz_next;
    logic                wram_en_reg, wram_en_next;
    logic                wram_prot_reg, wram_prot_next;
    logic [COUNT_W-1:0]  prg_count_reg;
    logic [COUNT_W-1:0]  chr_count_reg;
    logic                four_screen_reg;

    logic                out_valid_reg;
    xlate_t              result_reg;
    logic                wram_en_out_reg;
    logic                wram_wr_out_reg;

    logic                accept;
    mode_t               in_mode;
    logic [2:0]          reg_code;
    map_state_t          state;
    xlate_t              xlate;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign in_mode  = mode_t'(mode);
    assign reg_code = {address[14], address[13], address[0]};

    assign state.banks           = banks_reg;
    assign state.chr_swap        = chr_swap_reg;
    assign state.prg_swap        = prg_swap_reg;
    assign state.horiz_mirroring = horiz_reg;
    assign state.four_screen     = four_screen_reg;
    assign state.prg_count       = prg_count_reg;
    assign state.chr_count       = chr_count_reg;

    cbm_translate u_translate (
        .mode    (in_mode),
        .address (address),
        .state   (state),
        .result  (xlate)
    );

    // Mapper register writes; IRQ register codes fall through untouched
    always_comb
    begin
        banks_next       = banks_reg;
        bank_select_next = bank_select_reg;
        chr_swap_next    = chr_swap_reg;
        prg_swap_next    = prg_swap_reg;
        horiz_next       = horiz_reg;
        wram_en_next     = wram_en_reg;
        wram_prot_next   = wram_prot_reg;
        if (accept && in_mode == MODE_REG_WRITE)
        begin
            case (reg_code)
                REG_BANK_SELECT:
                begin
                    chr_swap_next    = data_byte[7];
                    prg_swap_next    = data_byte[6];
                    bank_select_next = data_byte[2:0];
                end
                REG_BANK_DATA:
                begin
                    banks_next[bank_select_reg] = data_byte;
                end
                REG_MIRRORING:
                begin
                    horiz_next = data_byte[0];
                end
                REG_WRAM_CTRL:
                begin
                    wram_en_next   = data_byte[7];
                    wram_prot_next = !data_byte[6];
                end
                default:
                begin
                    wram_en_next = wram_en_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            banks_reg       <= '0;
            bank_select_reg <= '0;
            chr_swap_reg    <= 1'b0;
            prg_swap_reg    <= 1'b0;
            horiz_reg       <= 1'b0;
            wram_en_reg     <= 1'b0;
            wram_prot_reg   <= 1'b1;
            prg_count_reg   <= PRG_COUNT_RESET;
            chr_count_reg   <= CHR_COUNT_RESET;
            four_screen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            banks_reg       <= banks_next;
            bank_select_reg <= bank_select_next;
            chr_swap_reg    <= chr_swap_next;
            prg_swap_reg    <= prg_swap_next;
            horiz_reg       <= horiz_next;
            wram_en_reg     <= wram_en_next;
            wram_prot_reg   <= wram_prot_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRG_BANK_COUNT: prg_count_reg   <= cfg_data;
                    CFG_CHR_BANK_COUNT: chr_count_reg   <= cfg_data;
                    CFG_FOUR_SCREEN:    four_screen_reg <= cfg_data[0];
                    default:            four_screen_reg <= four_screen_reg;
                endcase
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg      <= xlate;
            wram_en_out_reg <= wram_en_next;
            wram_wr_out_reg <= !wram_prot_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign target            = result_reg.target;
    assign mapped_offset     = result_reg.offset;
    assign bank_out_of_range = result_reg.out_of_range;
    assign wram_enabled      = wram_en_out_reg;
    assign wram_writable     = wram_wr_out_reg;

    // A work RAM control write shows its new bits on its own result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_REG_WRITE && reg_code == REG_WRAM_CTRL) |=>
        (wram_enabled == $past(data_byte[7]) && wram_writable == $past(data_byte[6])))
        else $error("work RAM bits do not follow the control write");

    // Only ROM targets can flag an out-of-range bank
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && target != TGT_PRG && target != TGT_CHR) |-> !bank_out_of_range)
        else $error("range flag set on a non-ROM target");

    // Every accepted beat produces a pending result on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted beat produced no result");

    // A register write never yields a memory target
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_REG_WRITE) |=> (target == TGT_NONE && mapped_offset == '0))
        else $error("register write produced a memory target");

endmodule

### test/cbm_checker.sv
// Result checker for cartridge_bank_mapper_top: watches both channels and the config port.
// Predicts each translated access and compares it with the result beats.
// Depends on cbm_pkg.
module cbm_checker
    import cbm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [1:0]             mode,
    input  logic [ADDR_W-1:0]      address,
    input  logic [DATA_W-1:0]      data_byte,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [2:0]             target,
    input  logic [OFFSET_W-1:0]    mapped_offset,
    input  logic                   bank_out_of_range,
    input  logic                   wram_enabled,
    input  logic                   wram_writable,
    output int                     mismatch_count,
    output int                     checked_count,
    output int                     results_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        target_t             tgt;
        logic [OFFSET_W-1:0] offset;
        logic                oob;
        logic                wen;
        logic                wwr;
    } access_result_t;

    // Mapper state as the block should hold it
    logic [DATA_W-1:0]  bank_reg [NUM_BANK_REGS];
    logic [2:0]         sel;
    logic               chr_swap;
    logic               prg_swap;
    logic               horiz;
    logic               wram_en;
    logic               wram_prot;
    logic [COUNT_W-1:0] prg_banks;
    logic [COUNT_W-1:0] chr_banks;
    logic               four_scr;

    access_result_t     translations [$];
    access_result_t     head;
    int                 mismatches = 0;
    int                 checked = 0;

    assign mismatch_count = mismatches;
    assign checked_count  = checked;

    function automatic access_result_t translate_access(logic [1:0] m, logic [ADDR_W-1:0] a,
                                                        logic [DATA_W-1:0] d);
        access_result_t     r;
        logic [13:0]        ppu;
        logic [COUNT_W-1:0] bank;
        logic [DATA_W-1:0]  chr8;
        logic [DATA_W-1:0]  pair;
        logic [2:0]         win;
        logic [21:0]        wide;
        ppu      = a[13:0];
        r.tgt    = TGT_NONE;
        r.offset = '0;
        r.oob    = 1'b0;
        case (m)
            MODE_REG_WRITE: begin
                case ({a[14], a[13], a[0]})
                    REG_BANK_SELECT: begin
                        chr_swap = d[7];
                        prg_swap = d[6];
                        sel      = d[2:0];
                    end
                    REG_BANK_DATA: bank_reg[sel] = d;
                    REG_MIRRORING: horiz = d[0];
                    REG_WRAM_CTRL: begin
                        wram_en   = d[7];
                        wram_prot = ~d[6];
                    end
                    default: ;  // scanline IRQ registers do nothing
                endcase
            end
            MODE_PRG_READ: begin
                if (a[15]) begin
                    case (a[14:13])
                        2'd0:    bank = prg_swap ? prg_banks - 9'd2 : {1'b0, bank_reg[6]};
                        2'd1:    bank = {1'b0, bank_reg[7]};
                        2'd2:    bank = prg_swap ? {1'b0, bank_reg[6]} : prg_banks - 9'd2;
                        default: bank = prg_banks - 9'd1;
                    endcase
                    wide     = {bank, a[12:0]};
                    r.tgt    = TGT_PRG;
                    r.offset = wide[OFFSET_W-1:0];
                    r.oob    = (bank >= prg_banks);
                end
            end
            MODE_CHR_READ: begin
                if (!ppu[13]) begin
                    win = ppu[12:10] ^ {chr_swap, 2'b00};
                    // low half pairs two 1 KB banks from one register
                    if (!win[2]) begin
                        pair = bank_reg[{2'b00, win[1]}];
                        chr8 = {pair[7:1], win[0]};
                    end else begin
                        chr8 = bank_reg[{1'b0, win[1:0]} + 3'd2];
                    end
                    r.tgt    = TGT_CHR;
                    r.offset = {3'b000, chr8, ppu[9:0]};
                    r.oob    = ({1'b0, chr8} >= chr_banks);
                end
            end
            default: begin
                // nametables, with 0x3000-0x3EFF folding onto 0x2000-0x2EFF
                if (ppu[13] && ppu[12:8] != 5'h1F) begin
                    r.tgt = TGT_VRAM;
                    if (four_scr) begin
                        r.tgt    = ppu[11] ? TGT_CART : TGT_VRAM;
                        r.offset = {10'd0, ppu[10], ppu[9:0]};
                    end else if (horiz) begin
                        r.offset = {10'd0, ppu[11], ppu[9:0]};
                    end else begin
                        r.offset = {10'd0, ppu[10], ppu[9:0]};
                    end
                end
            end
        endcase
        r.wen = wram_en;
        r.wwr = ~wram_prot;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANK_REGS; i++)
                bank_reg[i] = '0;
            sel       = '0;
            chr_swap  = 1'b0;
            prg_swap  = 1'b0;
            horiz     = 1'b0;
            wram_en   = 1'b0;
            wram_prot = 1'b1;
            prg_banks = PRG_COUNT_RESET;
            chr_banks = CHR_COUNT_RESET;
            four_scr  = 1'b0;
            translations.delete();
            results_waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRG_BANK_COUNT: prg_banks = cfg_data;
                    CFG_CHR_BANK_COUNT: chr_banks = cfg_data;
                    CFG_FOUR_SCREEN:    four_scr  = cfg_data[0];
                    default: ;
                endcase
            end
            // retire the oldest expectation before taking a new access
            if (out_valid && out_ready)
            begin
                if (translations.size() == 0)
                begin
                    $error("result beat with no access outstanding: target %0d offset 0x%06h",
                           target, mapped_offset);
                    mismatches++;
                end
                else
                begin
                    head = translations.pop_front();
                    checked++;
                    if (target !== head.tgt)
                    begin
                        $error("target: expected %0d, got %0d", head.tgt, target);
                        mismatches++;
                    end
                    if (mapped_offset !== head.offset)
                    begin
                        $error("mapped_offset: expected 0x%06h, got 0x%06h",
                               head.offset, mapped_offset);
                        mismatches++;
                    end
                    if (bank_out_of_range !== head.oob)
                    begin
                        $error("bank_out_of_range: expected %0b, got %0b",
                               head.oob, bank_out_of_range);
                        mismatches++;
                    end
                    if (wram_enabled !== head.wen)
                    begin
                        $error("wram_enabled: expected %0b, got %0b", head.wen, wram_enabled);
                        mismatches++;
                    end
                    if (wram_writable !== head.wwr)
                    begin
                        $error("wram_writable: expected %0b, got %0b", head.wwr, wram_writable);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                translations.push_back(translate_access(mode, address, data_byte));
            results_waiting <= translations.size();
        end
    end

endmodule

### test/tb.sv
// Testbench top for cartridge_bank_mapper_top: clock, reset, access and config stimulus.
// Checking is done by cbm_checker; depends on cbm_pkg and the mapper RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 200;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]     cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             mode;
    logic [ADDR_W-1:0]      address;
    logic [DATA_W-1:0]      data_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [2:0]             target;
    logic [OFFSET_W-1:0]    mapped_offset;
    logic                   bank_out_of_range;
    logic                   wram_enabled;
    logic                   wram_writable;
    int                     mismatch_count;
    int                     checked_count;
    int                     results_waiting;

    int                     cycle_count = 0;
    int                     accesses_sent = 0;
    int                     settings_used = 1;
    bit                     sender_gaps = 1'b0;
    bit                     receiver_stalls = 1'b0;
    bit                     hold_off_req = 1'b0;

    cartridge_bank_mapper_top DUT (.*);
    cbm_checker xlate_check (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one beat and hold it until taken; maybe idle afterward
    task automatic send_access(input mode_t m, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d);
        in_valid  <= 1'b1;
        mode      <= m;
        address   <= a;
        data_byte <= d;
        do @(posedge clk); while (!in_ready);
        accesses_sent++;
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_waiting != 0) @(posedge clk);
    endtask

    task automatic configure(input logic [COUNT_W-1:0] prg, input logic [COUNT_W-1:0] chr,
                             input logic fs);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRG_BANK_COUNT;
        cfg_data  <= prg;
        @(posedge clk);
        cfg_index <= CFG_CHR_BANK_COUNT;
        cfg_data  <= chr;
        @(posedge clk);
        cfg_index <= CFG_FOUR_SCREEN;
        cfg_data  <= {8'd0, fs};
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Mostly useful accesses, with a share of out-of-window and ignored ones
    task automatic random_access();
        mode_t             m;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        int                pick;
        pick = $urandom_range(0, 99);
        a    = ADDR_W'($urandom);
        d    = DATA_W'($urandom);
        if (pick < 30)
        begin
            m = MODE_REG_WRITE;
            if ($urandom_range(0, 3) != 0)
                a[14] = 1'b0;
        end
        else if (pick < 55)
        begin
            m = MODE_PRG_READ;
            if ($urandom_range(0, 7) != 0)
                a[15] = 1'b1;
        end
        else if (pick < 80)
        begin
            m = MODE_CHR_READ;
            if ($urandom_range(0, 7) != 0)
                a[13] = 1'b0;
        end
        else
        begin
            m = MODE_NT_ACCESS;
            if ($urandom_range(0, 7) != 0)
            begin
                a[13] = 1'b1;
                if (a[12:8] == 5'h1F)
                    a[8] = 1'b0;
            end
        end
        send_access(m, a, d);
    endtask

    task automatic directed_accesses();
        // program window edges under reset state
        send_access(MODE_PRG_READ, 16'h0000, 8'h00);
        send_access(MODE_PRG_READ, 16'h7FFF, 8'hFF);
        send_access(MODE_PRG_READ, 16'h8000, 8'h00);
        send_access(MODE_PRG_READ, 16'hA000, 8'h00);
        send_access(MODE_PRG_READ, 16'hC000, 8'h00);
        send_access(MODE_PRG_READ, 16'hFFFF, 8'h00);
        // enable and unprotect work RAM, swap both modes, select bank register 6
        send_access(MODE_REG_WRITE, 16'hA001, 8'hC0);
        send_access(MODE_REG_WRITE, 16'h8000, 8'hC6);
        send_access(MODE_REG_WRITE, 16'h8001, 8'hFF);
        send_access(MODE_PRG_READ, 16'h8000, 8'h00);
        send_access(MODE_PRG_READ, 16'hC000, 8'h00);
        // scanline IRQ register, then work RAM control with bit 15 clear
        send_access(MODE_REG_WRITE, 16'hE001, 8'hFF);
        send_access(MODE_REG_WRITE, 16'h2001, 8'h00);
        send_access(MODE_REG_WRITE, 16'hA000, 8'h01);
        send_access(MODE_CHR_READ, 16'h0000, 8'h00);
        send_access(MODE_CHR_READ, 16'h1FFF, 8'h00);
        send_access(MODE_CHR_READ, 16'h2000, 8'h00);
        send_access(MODE_CHR_READ, 16'hFFFF, 8'h00);
        // nametables: plain, fourth table, mirrored top, palette, below range
        send_access(MODE_NT_ACCESS, 16'h2000, 8'h00);
        send_access(MODE_NT_ACCESS, 16'h2C00, 8'h00);
        send_access(MODE_NT_ACCESS, 16'h3EFF, 8'h00);
        send_access(MODE_NT_ACCESS, 16'h3F00, 8'h00);
        send_access(MODE_NT_ACCESS, 16'h1FFF, 8'h00);
        send_access(MODE_REG_WRITE, 16'h0000, 8'h00);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_PRG_BANK_COUNT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        mode      <= MODE_REG_WRITE;
        address   <= '0;
        data_byte <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        directed_accesses();
        repeat (60) random_access();

        for (int phase = 1; phase <= 7; phase++)
        begin
            drain_results();
            case (phase)
                1: configure(9'd2, 9'd8, 1'b0);
                2: configure(9'd256, 9'd256, 1'b1);
                3: configure(9'd1, 9'd0, 1'b1);
                4: configure(9'd511, 9'd511, 1'b0);
                5: configure(9'd0, 9'd1, 1'b1);
                6: configure(COUNT_W'($urandom_range(2, 256)),
                             COUNT_W'($urandom_range(8, 256)),
                             1'($urandom_range(0, 1)));
                default:
                begin
                    sender_gaps     = 1'b0;
                    receiver_stalls = 1'b0;
                    configure(PRG_COUNT_RESET, CHR_COUNT_RESET, 1'b0);
                end
            endcase
            if (phase == 2)
            begin
                // back the block up behind a stalled receiver
                sender_gaps  = 1'b0;
                hold_off_req = 1'b1;
                repeat (24) random_access();
                sender_gaps  = 1'b1;
            end
            repeat (60) random_access();
        end

        drain_results();
        repeat (4) @(posedge clk);
        $display("Checked %0d results from %0d accesses over %0d bank-count/mirroring settings,",
                 checked_count, accesses_sent, settings_used);
        $display("including zero, one and 511 bank counts and a long result hold-off.");
        if (mismatch_count == 0 && results_waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### cartridge_bank_mapper_top.f
src/cbm_pkg.sv
src/cbm_translate.sv
src/cartridge_bank_mapper_top.sv
test/cbm_checker.sv
test/tb.sv
